FILE: rtl/core/lcdx_pkg.sv
// lcdx_pkg: types and constants shared by the character lcd expander writer
// no dependencies; imported by every module in rtl/core
package lcdx_pkg;

	localparam logic [1:0] OP_CMD    = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_CURSOR = 2'd2;
	localparam logic [1:0] OP_INIT   = 2'd3;

	localparam logic [2:0] REG_BACKLIGHT = 3'd0;
	localparam logic [2:0] REG_PULSE     = 3'd1;
	localparam logic [2:0] REG_DATA_WAIT = 3'd2;
	localparam logic [2:0] REG_SHORT     = 3'd3;
	localparam logic [2:0] REG_LONG      = 3'd4;
	localparam logic [2:0] REG_INIT_NIB  = 3'd5;
	localparam logic [2:0] REG_POWERUP   = 3'd6;

	localparam int WAIT_W = 20;

	localparam logic [WAIT_W-1:0] RST_PULSE     = 20'd1;
	localparam logic [WAIT_W-1:0] RST_DATA_WAIT = 20'd50;
	localparam logic [WAIT_W-1:0] RST_SHORT     = 20'd1000;
	localparam logic [WAIT_W-1:0] RST_LONG      = 20'd20000;
	localparam logic [WAIT_W-1:0] RST_INIT_NIB  = 20'd5000;
	localparam logic [WAIT_W-1:0] RST_POWERUP   = 20'd100000;

	localparam logic [7:0] BASE_ROW0 = 8'h80;
	localparam logic [7:0] BASE_ROW1 = 8'hC0;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME  = 8'h02;

	localparam logic [3:0] NIB_RESET = 4'h3;
	localparam logic [3:0] NIB_4BIT  = 4'h2;

	// run lengths in expander bytes
	localparam int RUN_LEN     = 4;
	localparam int RESET_BYTES = 8;
	localparam int INIT_LEN    = 28;
	localparam int STEP_W      = 5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] value;
		logic       row;
		logic [5:0] col;
	} req_t;

	typedef struct packed {
		logic [7:0]        expander_byte;
		logic [WAIT_W-1:0] wait_before_us;
		logic [WAIT_W-1:0] wait_after_us;
		logic              last;
	} res_t;

	// classified request handed from front to back
	typedef struct packed {
		logic       is_init;
		logic       sel;
		logic [7:0] byte_val;
	} job_t;

	typedef struct packed {
		logic              backlight_on;
		logic [WAIT_W-1:0] pulse_wait_us;
		logic [WAIT_W-1:0] data_wait_us;
		logic [WAIT_W-1:0] short_cmd_wait_us;
		logic [WAIT_W-1:0] long_cmd_wait_us;
		logic [WAIT_W-1:0] init_nibble_wait_us;
		logic [WAIT_W-1:0] powerup_wait_us;
	} cfg_t;

	// set-up commands sent after the nibble reset
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h28;
			3'd1: c = 8'h08;
			3'd2: c = 8'h01;
			3'd3: c = 8'h06;
			3'd4: c = 8'h0C;
			default: c = 8'h0C;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/lcdx_front.sv
// lcdx_front: accepts requests and turns them into jobs for the queue
// depends on lcdx_pkg
module lcdx_front (
	input  logic           req_valid,
	output logic           req_ready,
	input  lcdx_pkg::req_t req,
	input  logic           q_full,
	output logic           q_push,
	output lcdx_pkg::job_t q_job
);
	import lcdx_pkg::*;

	logic [7:0] cursor_byte;

	assign req_ready   = !q_full;
	assign q_push      = req_valid && !q_full;
	assign cursor_byte = (req.row ? BASE_ROW1 : BASE_ROW0) + {2'b00, req.col};

	always_comb begin
		q_job = '0;
		case (req.opcode)
			OP_CMD: begin
				q_job.byte_val = req.value;
			end
			OP_DATA: begin
				q_job.sel      = 1'b1;
				q_job.byte_val = req.value;
			end
			OP_CURSOR: begin
				q_job.byte_val = cursor_byte;
			end
			default: begin
				q_job.is_init = 1'b1;
			end
		endcase
	end

endmodule

FILE: rtl/core/lcdx_queue.sv
// lcdx_queue: short job fifo between front and back
// depends on lcdx_pkg
module lcdx_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcdx_pkg::job_t push_job,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output lcdx_pkg::job_t head
);
	import lcdx_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/lcdx_back.sv
// lcdx_back: sequencer that expands one job into its run of expander bytes
// depends on lcdx_pkg; output register feeds the result channel
module lcdx_back (
	input  logic           clk,
	input  logic           arst_n,
	input  lcdx_pkg::cfg_t cfg,
	input  logic           q_not_empty,
	input  lcdx_pkg::job_t q_head,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output lcdx_pkg::res_t res
);
	import lcdx_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_state_t;

	back_state_t       state_q;
	job_t              job_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              advance;
	logic              in_reset;
	logic [2:0]        cmd_idx;
	logic [7:0]        cur_byte;
	logic              long_cmd;
	logic [3:0]        nibble;
	logic [STEP_W-1:0] final_step;
	logic              is_last;
	logic [WAIT_W-1:0] final_wait;
	res_t              next_res;

	assign q_pop   = (state_q == ST_IDLE) && q_not_empty;
	assign advance = (state_q == ST_RUN) && (!out_valid_q || res_ready);

	assign in_reset   = job_q.is_init && (step_q < STEP_W'(RESET_BYTES));
	assign cmd_idx    = step_q[STEP_W-1:2] - 3'd2;
	assign cur_byte   = job_q.is_init ? init_cmd(cmd_idx) : job_q.byte_val;
	assign long_cmd   = (cur_byte == CMD_CLEAR) || (cur_byte == CMD_HOME);
	assign final_step = job_q.is_init ? STEP_W'(INIT_LEN - 1) : STEP_W'(RUN_LEN - 1);
	assign is_last    = step_q == final_step;
	assign final_wait = job_q.sel ? cfg.data_wait_us :
	                    (long_cmd ? cfg.long_cmd_wait_us : cfg.short_cmd_wait_us);

	always_comb begin
		if (in_reset) begin
			nibble = (step_q[2:1] == 2'b11) ? NIB_4BIT : NIB_RESET;
		end else begin
			nibble = step_q[1] ? cur_byte[3:0] : cur_byte[7:4];
		end
		next_res.expander_byte  = {nibble, cfg.backlight_on, !step_q[0], 1'b0, job_q.sel};
		next_res.wait_before_us = (job_q.is_init && step_q == '0) ? cfg.powerup_wait_us : '0;
		// enable-high byte waits the pulse, enable-low byte closes the nibble
		if (!step_q[0]) begin
			next_res.wait_after_us = cfg.pulse_wait_us;
		end else if (in_reset) begin
			next_res.wait_after_us = cfg.init_nibble_wait_us;
		end else if (!step_q[1]) begin
			next_res.wait_after_us = '0;
		end else begin
			next_res.wait_after_us = final_wait;
		end
		next_res.last = is_last;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (advance) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (advance) begin
						if (is_last) begin
							state_q <= ST_IDLE;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_W'(INIT_LEN))
		else $error("step counter past end of run");

	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (step_q == '0))
		else $error("step counter not cleared while idle");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_last) |=> (state_q == ST_IDLE && out_valid_q && out_q.last))
		else $error("run did not end on its last byte");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_RUN))
		else $error("job popped without starting a run");

endmodule

FILE: rtl/core/char_lcd_nibble_expander_writer.sv
// char_lcd_nibble_expander_writer: top level with register file and handshakes
// depends on lcdx_pkg, lcdx_front, lcdx_queue, lcdx_back
// flow: an accepted request is written into the job queue, the sequencer loads it while idle,
// then its bytes pass the output register, one byte per cycle within a run while res_ready holds
// a command, data or cursor request expands to 4 bytes, an init to 28; each job load takes the
// idle state of the byte sequencer, and the job queue lets the next requests enter meanwhile
// reset: asynchronous, clears queue, sequencer and output valid; registers take their defaults
module char_lcd_nibble_expander_writer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lcdx_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output lcdx_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import lcdx_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_we;
	logic [2:0] reg_idx;

	logic q_full, q_push, q_not_empty, q_pop;
	job_t q_job, q_head;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backlight_on        <= 1'b1;
			cfg_q.pulse_wait_us       <= RST_PULSE;
			cfg_q.data_wait_us        <= RST_DATA_WAIT;
			cfg_q.short_cmd_wait_us   <= RST_SHORT;
			cfg_q.long_cmd_wait_us    <= RST_LONG;
			cfg_q.init_nibble_wait_us <= RST_INIT_NIB;
			cfg_q.powerup_wait_us     <= RST_POWERUP;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_BACKLIGHT: cfg_q.backlight_on        <= pwdata[0];
				REG_PULSE:     cfg_q.pulse_wait_us       <= pwdata[WAIT_W-1:0];
				REG_DATA_WAIT: cfg_q.data_wait_us        <= pwdata[WAIT_W-1:0];
				REG_SHORT:     cfg_q.short_cmd_wait_us   <= pwdata[WAIT_W-1:0];
				REG_LONG:      cfg_q.long_cmd_wait_us    <= pwdata[WAIT_W-1:0];
				REG_INIT_NIB:  cfg_q.init_nibble_wait_us <= pwdata[WAIT_W-1:0];
				REG_POWERUP:   cfg_q.powerup_wait_us     <= pwdata[WAIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BACKLIGHT: prdata = {31'd0, cfg_q.backlight_on};
			REG_PULSE:     prdata = {12'd0, cfg_q.pulse_wait_us};
			REG_DATA_WAIT: prdata = {12'd0, cfg_q.data_wait_us};
			REG_SHORT:     prdata = {12'd0, cfg_q.short_cmd_wait_us};
			REG_LONG:      prdata = {12'd0, cfg_q.long_cmd_wait_us};
			REG_INIT_NIB:  prdata = {12'd0, cfg_q.init_nibble_wait_us};
			REG_POWERUP:   prdata = {12'd0, cfg_q.powerup_wait_us};
			default:       prdata = '0;
		endcase
	end

	lcdx_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	lcdx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_job),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (q_head)
	);

	lcdx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for char_lcd_nibble_expander_writer
// depends on lcdx_pkg and the rtl/core sources; predicts every expander word from the
// register settings and each accepted request, with random idling on both channels
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdx_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 3;
	localparam int DRAIN_CYCLES     = 8;
	localparam int HOLD_CYCLES      = 300;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int RANDOM_PER_PHASE = 40;
	localparam int NUM_PHASES       = 5;

	localparam logic [7:0] EXP_BACKLIGHT = 8'h08;
	localparam logic [7:0] EXP_ENABLE    = 8'h04;
	localparam logic [7:0] EXP_SELECT    = 8'h01;
	localparam logic       RST_BACKLIGHT = 1'b1;
	// index past the register file, writes must be dropped
	localparam logic [2:0] REG_UNUSED    = 3'd7;

	// expected expander words, built from a private copy of the registers
	class expander_run_board;
		cfg_t cfg;
		res_t want_bytes[$];
		int   errors;
		int   checked;

		function new();
			cfg.backlight_on        = RST_BACKLIGHT;
			cfg.pulse_wait_us       = RST_PULSE;
			cfg.data_wait_us        = RST_DATA_WAIT;
			cfg.short_cmd_wait_us   = RST_SHORT;
			cfg.long_cmd_wait_us    = RST_LONG;
			cfg.init_nibble_wait_us = RST_INIT_NIB;
			cfg.powerup_wait_us     = RST_POWERUP;
			errors  = 0;
			checked = 0;
		endfunction

		function void write_reg(input logic [2:0] idx, input logic [31:0] d);
			case (idx)
				REG_BACKLIGHT: cfg.backlight_on = d[0];
				REG_PULSE:     cfg.pulse_wait_us = d[WAIT_W-1:0];
				REG_DATA_WAIT: cfg.data_wait_us = d[WAIT_W-1:0];
				REG_SHORT:     cfg.short_cmd_wait_us = d[WAIT_W-1:0];
				REG_LONG:      cfg.long_cmd_wait_us = d[WAIT_W-1:0];
				REG_INIT_NIB:  cfg.init_nibble_wait_us = d[WAIT_W-1:0];
				REG_POWERUP:   cfg.powerup_wait_us = d[WAIT_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_byte(input logic [7:0] b, input logic [WAIT_W-1:0] after);
			res_t r;
			r.expander_byte  = b;
			r.wait_before_us = '0;
			r.wait_after_us  = after;
			r.last           = 1'b0;
			want_bytes.push_back(r);
		endfunction

		// enable-high word then enable-low word for one nibble
		function void push_nibble(input logic [3:0] nib, input logic sel,
				input logic [WAIT_W-1:0] after);
			logic [7:0] b;
			b = {nib, 4'h0};
			if (cfg.backlight_on) b = b | EXP_BACKLIGHT;
			if (sel) b = b | EXP_SELECT;
			push_byte(b | EXP_ENABLE, cfg.pulse_wait_us);
			push_byte(b, after);
		endfunction

		function void push_full(input logic [7:0] v, input logic sel,
				input logic [WAIT_W-1:0] final_wait);
			push_nibble(v[7:4], sel, '0);
			push_nibble(v[3:0], sel, final_wait);
		endfunction

		function void push_cmd(input logic [7:0] c);
			push_full(c, 1'b0, (c == CMD_CLEAR || c == CMD_HOME) ?
				cfg.long_cmd_wait_us : cfg.short_cmd_wait_us);
		endfunction

		function void note_request(input req_t q);
			int   head;
			res_t r;
			head = want_bytes.size();
			case (q.opcode)
				OP_CMD:    push_cmd(q.value);
				OP_DATA:   push_full(q.value, 1'b1, cfg.data_wait_us);
				OP_CURSOR: push_cmd((q.row ? BASE_ROW1 : BASE_ROW0) + {2'b00, q.col});
				default: begin
					push_nibble(NIB_RESET, 1'b0, cfg.init_nibble_wait_us);
					push_nibble(NIB_RESET, 1'b0, cfg.init_nibble_wait_us);
					push_nibble(NIB_RESET, 1'b0, cfg.init_nibble_wait_us);
					push_nibble(NIB_4BIT, 1'b0, cfg.init_nibble_wait_us);
					// function set, display off, clear, entry mode, display on
					push_cmd(8'h28);
					push_cmd(8'h08);
					push_cmd(CMD_CLEAR);
					push_cmd(8'h06);
					push_cmd(8'h0C);
					r = want_bytes[head];
					r.wait_before_us = cfg.powerup_wait_us;
					want_bytes[head] = r;
				end
			endcase
			r = want_bytes[want_bytes.size()-1];
			r.last = 1'b1;
			want_bytes[want_bytes.size()-1] = r;
		endfunction

		function void check_byte(input res_t got);
			res_t want;
			if (want_bytes.size() == 0) begin
				$error("unexpected word: expander_byte %h last %b", got.expander_byte, got.last);
				errors++;
				return;
			end
			want = want_bytes.pop_front();
			checked++;
			if (got.expander_byte !== want.expander_byte) begin
				$error("expander_byte expected %h actual %h", want.expander_byte,
					got.expander_byte);
				errors++;
			end
			if (got.wait_before_us !== want.wait_before_us) begin
				$error("wait_before_us expected %0d actual %0d", want.wait_before_us,
					got.wait_before_us);
				errors++;
			end
			if (got.wait_after_us !== want.wait_after_us) begin
				$error("wait_after_us expected %0d actual %0d", want.wait_after_us,
					got.wait_after_us);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %b actual %b", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return want_bytes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	expander_run_board sb;
	int burst_left = 0;
	int op_count[4] = '{0, 0, 0, 0};
	int input_stalls = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;

	char_lcd_nibble_expander_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) sb.check_byte(res);
		if (req_valid && !req_ready) input_stalls++;
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: segments of steady, random and mostly-stalled ready, plus one long hold
	initial begin
		int mode;
		int span;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_seen = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(1, 30);
			repeat (span) begin
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					default: res_ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] d);
		logic rdy;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		sb.write_reg(idx, d);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// bus returns to idle between transfers
		@(posedge clk);
	endtask

	function automatic logic [31:0] wait_word(input int kind);
		case (kind)
			0: return 32'hFFF0_0000;    // junk above bit 19, zero once masked
			1: return 32'hFFFF_FFFF;
			2: return 32'd1000000;
			default: begin
				case ($urandom_range(0, 3))
					0: return $urandom_range(0, 20);
					1: return $urandom_range(0, 1000000);
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic program_regs(input int kind);
		logic [31:0] bl;
		bl = $urandom;
		case (kind)
			0: bl[0] = 1'b0;
			1: bl[0] = 1'b1;
			2: bl[0] = 1'b0;
			default: bl[0] = 1'($urandom_range(0, 1));
		endcase
		apb_write(REG_BACKLIGHT, bl);
		for (int i = REG_PULSE; i <= REG_POWERUP; i++) apb_write(i[2:0], wait_word(kind));
		apb_write(REG_UNUSED, $urandom);
	endtask

	task automatic offer(input req_t q);
		logic took;
		int   gap;
		req       <= q;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = req_ready;
			@(posedge clk);
		end while (!took);
		sb.note_request(q);
		op_count[q.opcode]++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drop valid and let every outstanding word drain before touching registers
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic req_t mk(input logic [1:0] op, input logic [7:0] v,
			input logic r, input logic [5:0] c);
		req_t q;
		q.opcode = op;
		q.value  = v;
		q.row    = r;
		q.col    = c;
		return q;
	endfunction

	function automatic req_t rand_request();
		req_t q;
		int   pick;
		q.value = 8'($urandom_range(0, 255));
		q.row   = 1'($urandom_range(0, 1));
		q.col   = 6'($urandom_range(0, 63));
		pick    = $urandom_range(0, 99);
		if (pick < 30) begin
			q.opcode = OP_CMD;
			if ($urandom_range(0, 3) == 0) q.value = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
		end else if (pick < 65) begin
			q.opcode = OP_DATA;
		end else if (pick < 90) begin
			q.opcode = OP_CURSOR;
			if ($urandom_range(0, 7) != 0) q.col = 6'($urandom_range(0, 39));
		end else begin
			q.opcode = OP_INIT;
		end
		return q;
	endfunction

	initial begin
		req_t directed[$];
		sb = new();
		directed.push_back(mk(OP_CMD, 8'h00, 1'b0, 6'd0));
		directed.push_back(mk(OP_CMD, 8'hFF, 1'b1, 6'd63));
		directed.push_back(mk(OP_CMD, CMD_CLEAR, 1'b0, 6'd0));
		directed.push_back(mk(OP_CMD, CMD_HOME, 1'b0, 6'd0));
		directed.push_back(mk(OP_CMD, 8'h03, 1'b0, 6'd0));
		directed.push_back(mk(OP_DATA, 8'h00, 1'b0, 6'd0));
		directed.push_back(mk(OP_DATA, 8'hFF, 1'b1, 6'd63));
		directed.push_back(mk(OP_DATA, 8'hA5, 1'b0, 6'd0));
		directed.push_back(mk(OP_DATA, 8'h5A, 1'b0, 6'd0));
		// cursor: line bases, last visible column, columns past the line end
		directed.push_back(mk(OP_CURSOR, 8'hFF, 1'b0, 6'd0));
		directed.push_back(mk(OP_CURSOR, 8'h00, 1'b0, 6'd39));
		directed.push_back(mk(OP_CURSOR, 8'h01, 1'b1, 6'd0));
		directed.push_back(mk(OP_CURSOR, 8'h02, 1'b1, 6'd39));
		directed.push_back(mk(OP_CURSOR, 8'h00, 1'b0, 6'd63));
		directed.push_back(mk(OP_CURSOR, 8'h00, 1'b1, 6'd63));
		directed.push_back(mk(OP_CURSOR, 8'h00, 1'b1, 6'd40));
		directed.push_back(mk(OP_INIT, 8'hFF, 1'b1, 6'd63));
		directed.push_back(mk(OP_INIT, 8'h00, 1'b0, 6'd0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) offer(directed[i]);
		settle();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			program_regs(phase);
			// long receiver hold while requests keep coming
			if (phase == 1) hold_req = 1'b1;
			repeat (RANDOM_PER_PHASE) offer(rand_request());
			settle();
		end

		$display("covered %0d commands, %0d data, %0d cursor, %0d init requests; %0d words checked",
			op_count[OP_CMD], op_count[OP_DATA], op_count[OP_CURSOR], op_count[OP_INIT],
			sb.checked);
		$display("%0d register phases incl. zero and max waits, %0d input stall cycles, hold %0s",
			NUM_PHASES + 1, input_stalls, hold_seen ? "done" : "missed");
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/lcdx_pkg.sv
rtl/core/lcdx_front.sv
rtl/core/lcdx_queue.sv
rtl/core/lcdx_back.sv
rtl/core/char_lcd_nibble_expander_writer.sv
tb/tb.sv
